// ----- hw/rtl/m3alu_pkg.sv -----
// Shared types, constants and helpers for the 3x3 matrix arithmetic unit.
`default_nettype none

package m3alu_pkg;

  localparam int ELEM_W  = 32;
  localparam int DIM     = 3;
  localparam int ELEMS   = DIM * DIM;
  localparam int IDX_W   = 4;
  localparam int SUB_W   = 2;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_SUB  = 2'd1,
    OP_PROD = 2'd2,
    OP_SCAL = 2'd3
  } m3_op_t;

  typedef enum logic {
    ST_LOAD = 1'b0,
    ST_RUN  = 1'b1
  } m3_state_t;

  // Tag that travels with one term through the datapath.
  typedef struct packed {
    logic             vld;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] idx;
  } m3_tag_t;

  // Finished result element handed back to the top level.
  typedef struct packed {
    logic                     vld;
    logic                     sat;
    logic [IDX_W-1:0]         idx;
    logic signed [ELEM_W-1:0] elem;
  } m3_res_t;

  // Column-major position of (major, minor): major*3 + minor.
  function automatic logic [IDX_W-1:0] m3_pos(input logic [SUB_W-1:0] major,
                                              input logic [SUB_W-1:0] minor);
    m3_pos = {1'b0, major, 1'b0} + {2'b00, major} + {2'b00, minor};
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/m3alu_in_if.sv -----
// Request channel: one element pair plus opcode and scalar.
`default_nettype none

interface m3alu_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] a_elem;
  logic signed [31:0] b_elem;
  logic signed [31:0] scalar;

  modport source (output valid, output opcode, output a_elem, output b_elem,
                  output scalar, input ready);
  modport sink   (input valid, input opcode, input a_elem, input b_elem,
                  input scalar, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/m3alu_out_if.sv -----
// Result channel: one result element with its position and flags.
`default_nettype none

interface m3alu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_elem;
  logic [3:0]         elem_index;
  logic               is_last;
  logic               saturated;

  modport source (output valid, output result_elem, output elem_index,
                  output is_last, output saturated, input ready);
  modport sink   (input valid, input result_elem, input elem_index,
                  input is_last, input saturated, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/matrix3_alu_unit.sv -----
// Top level of the 3x3 matrix arithmetic unit on signed Q15.16 elements.
// Nine requests load matrices A and B in column-major order, one element pair
// per request; opcode and scalar are captured from the first request of each
// group. After the ninth request the unit emits nine result elements in
// column-major order (add, subtract, matrix product or A times scalar), each
// clipped to 32 bits with a saturated flag. While loading, every valid
// request is taken. Results are computed one element at a time from two
// 9-entry synchronous memories with one read port each: an element issues
// its terms back to back (three for the product, one otherwise), which then
// pass through the term, accumulate and round/clip stages and into the
// output register; the next element is issued only once the output register
// has drained. No new request is taken until the last result of a group sits
// in the output register.
`default_nettype none

module matrix3_alu_unit #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  m3alu_in_if.sink   in_req,
  m3alu_out_if.source out_res
);
  import m3alu_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ELEMS - 1);
  localparam logic [SUB_W-1:0] DIM_END  = SUB_W'(DIM);
  localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(DIM - 1);

  // Element stores, written on each request, read while computing.
  logic signed [ELEM_W-1:0] first_mem  [ELEMS];
  logic signed [ELEM_W-1:0] second_mem [ELEMS];
  logic signed [ELEM_W-1:0] a_q;
  logic signed [ELEM_W-1:0] b_q;

  m3_state_t                state_r, state_nxt;
  logic [IDX_W-1:0]         load_cnt_r, load_cnt_nxt;
  m3_op_t                   op_r;
  logic signed [ELEM_W-1:0] scalar_r;
  logic [SUB_W-1:0]         row_r, row_nxt;
  logic [SUB_W-1:0]         col_r, col_nxt;
  logic [SUB_W-1:0]         k_r, k_nxt;
  logic                     busy_r, busy_nxt;
  logic                     acc_in;
  logic                     take_first;
  logic                     iss_go;
  logic [SUB_W-1:0]         k_end;
  logic [IDX_W-1:0]         a_addr;
  logic [IDX_W-1:0]         b_addr;
  m3_tag_t                  iss_tag;
  m3_tag_t                  tag1_r;
  m3_res_t                  res;

  logic                     out_vld_r;
  logic signed [ELEM_W-1:0] out_elem_r;
  logic [IDX_W-1:0]         out_idx_r;
  logic                     out_sat_r;

  // Take requests only while loading.
  assign in_req.ready = (state_r == ST_LOAD);

  assign acc_in     = in_req.valid && in_req.ready;
  assign take_first = acc_in && (load_cnt_r == '0);

  // Hold opcode and scalar for the whole group.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r     <= OP_ADD;
      scalar_r <= '0;
    end else if (take_first) begin
      op_r     <= m3_op_t'(in_req.opcode);
      scalar_r <= in_req.scalar;
    end
  end

  // Read addresses: product walks row of A and column of B over k.
  always_comb begin
    k_end = (op_r == OP_PROD) ? SUB_LAST : '0;
    if (op_r == OP_PROD) begin
      a_addr = m3_pos(k_r, row_r);
      b_addr = m3_pos(col_r, k_r);
    end else begin
      a_addr = m3_pos(col_r, row_r);
      b_addr = m3_pos(col_r, row_r);
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      first_mem[load_cnt_r]  <= in_req.a_elem;
      second_mem[load_cnt_r] <= in_req.b_elem;
    end
    a_q <= first_mem[a_addr];
    b_q <= second_mem[b_addr];
  end

  // Sequencer: load nine pairs, then issue terms element by element.
  always_comb begin
    state_nxt    = state_r;
    load_cnt_nxt = load_cnt_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    k_nxt        = k_r;
    busy_nxt     = busy_r;
    iss_go       = 1'b0;

    unique case (state_r)
      ST_LOAD: begin
        if (acc_in) begin
          if (load_cnt_r == LAST_IDX) begin
            load_cnt_nxt = '0;
            state_nxt    = ST_RUN;
          end else begin
            load_cnt_nxt = load_cnt_r + 1'b1;
          end
        end
      end
      ST_RUN: begin
        // Start a new element only with nothing in flight and a free slot.
        iss_go = (col_r != DIM_END) &&
                 ((k_r != '0) || (!busy_r && !out_vld_r));
        if (iss_go) begin
          if (k_r == '0) begin
            busy_nxt = 1'b1;
          end
          if (k_r == k_end) begin
            k_nxt = '0;
            if (row_r == SUB_LAST) begin
              row_nxt = '0;
              col_nxt = col_r + 1'b1;
            end else begin
              row_nxt = row_r + 1'b1;
            end
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
        if (res.vld) begin
          busy_nxt = 1'b0;
          if (res.idx == LAST_IDX) begin
            state_nxt = ST_LOAD;
            col_nxt   = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    iss_tag.vld   = iss_go;
    iss_tag.first = (k_r == '0);
    iss_tag.last  = (k_r == k_end);
    iss_tag.idx   = m3_pos(col_r, row_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      load_cnt_r <= '0;
      row_r      <= '0;
      col_r      <= '0;
      k_r        <= '0;
      busy_r     <= 1'b0;
      tag1_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      k_r        <= k_nxt;
      busy_r     <= busy_nxt;
      // Align the tag with the read data.
      tag1_r     <= iss_tag;
    end
  end

  m3alu_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .op     (op_r),
    .scalar (scalar_r),
    .a_q    (a_q),
    .b_q    (b_q),
    .tag    (tag1_r),
    .res    (res)
  );

  // Output register: filled by a finished element, drained by the sink.
  always_ff @(posedge clk) begin
    if (res.vld) begin
      out_elem_r <= res.elem;
      out_idx_r  <= res.idx;
      out_sat_r  <= res.sat;
    end
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res.vld) begin
      out_vld_r <= 1'b1;
    end else if (out_res.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_res.valid       = out_vld_r;
  assign out_res.result_elem = out_elem_r;
  assign out_res.elem_index  = out_idx_r;
  assign out_res.is_last     = (out_idx_r == LAST_IDX);
  assign out_res.saturated   = out_sat_r;

endmodule

`default_nettype wire

// ----- hw/rtl/m3alu_mac.sv -----
// Term, accumulate and round/clip datapath of the 3x3 matrix unit.
`default_nettype none

module m3alu_mac #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire m3alu_pkg::m3_op_t   op,
  input  wire logic signed [31:0]  scalar,
  input  wire logic signed [31:0]  a_q,
  input  wire logic signed [31:0]  b_q,
  input  wire m3alu_pkg::m3_tag_t  tag,
  output m3alu_pkg::m3_res_t       res
);
  import m3alu_pkg::*;

  localparam int ACC_W = 2 * ELEM_W + 2;
  localparam logic signed [ACC_W-1:0] HALF = (ACC_W'(1) << FRAC_BITS) >> 1;
  localparam logic signed [ELEM_W-1:0] EMAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic signed [ELEM_W-1:0] EMIN = {1'b1, {(ELEM_W-1){1'b0}}};

  logic signed [ELEM_W-1:0]   m_x;
  logic signed [2*ELEM_W-1:0] mul_w;
  logic signed [ELEM_W:0]     sum_w;
  logic signed [2*ELEM_W-1:0] term_nxt;
  logic signed [2*ELEM_W-1:0] term_r;
  m3_tag_t                    tag2_r;
  logic signed [ACC_W-1:0]    acc_nxt;
  logic signed [ACC_W-1:0]    acc_r;
  logic                       fin_vld_r;
  logic [IDX_W-1:0]           fin_idx_r;
  logic signed [ACC_W-1:0]    rnd_w;
  logic signed [ACC_W-1:0]    val_w;
  logic                       hi_ok;
  logic                       lo_ok;

  // Stage 1: form the term from the read data.
  always_comb begin
    m_x   = (op == OP_SCAL) ? scalar : b_q;
    mul_w = a_q * m_x;
    sum_w = (op == OP_SUB) ? ({a_q[ELEM_W-1], a_q} - {b_q[ELEM_W-1], b_q})
                           : ({a_q[ELEM_W-1], a_q} + {b_q[ELEM_W-1], b_q});
    if (op == OP_ADD || op == OP_SUB) begin
      term_nxt = {{(ELEM_W-1){sum_w[ELEM_W]}}, sum_w};
    end else begin
      term_nxt = mul_w;
    end
  end

  always_ff @(posedge clk) begin
    term_r <= term_nxt;
    if (!rst_n) begin
      tag2_r <= '0;
    end else begin
      tag2_r <= tag;
    end
  end

  // Stage 2: accumulate; restart on the first term of an element.
  always_comb begin
    acc_nxt = (tag2_r.first ? '0 : acc_r) + {{2{term_r[2*ELEM_W-1]}}, term_r};
  end

  always_ff @(posedge clk) begin
    if (tag2_r.vld) begin
      acc_r     <= acc_nxt;
      fin_idx_r <= tag2_r.idx;
    end
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else begin
      fin_vld_r <= tag2_r.vld & tag2_r.last;
    end
  end

  // Stage 3: for product and scalar, round to nearest (ties up); then clip to 32 bits.
  always_comb begin
    rnd_w = (acc_r + HALF) >>> FRAC_BITS;
    val_w = (op == OP_PROD || op == OP_SCAL) ? rnd_w : acc_r;
    hi_ok = ~|val_w[ACC_W-1:ELEM_W-1];
    lo_ok = &val_w[ACC_W-1:ELEM_W-1];
    res.vld = fin_vld_r;
    res.idx = fin_idx_r;
    res.sat = !(hi_ok || lo_ok);
    if (hi_ok || lo_ok) begin
      res.elem = val_w[ELEM_W-1:0];
    end else if (val_w[ACC_W-1]) begin
      res.elem = EMIN;
    end else begin
      res.elem = EMAX;
    end
  end

endmodule

`default_nettype wire
